// ----- rtl/fdtd_2d_tm_grid_step_top_defines.svh -----
// Assertion macros shared by the grid step RTL
`ifndef FDTD_2D_TM_GRID_STEP_TOP_DEFINES_SVH
`define FDTD_2D_TM_GRID_STEP_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define FDTD_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FDTD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/fdtd_pkg.sv -----
// Shared types, codes and helpers for the 2D TM grid step engine
package fdtd_pkg;

   localparam int GRID_COLS_DEF = 64;
   localparam int GRID_ROWS_DEF = 64;
   localparam int DATA_W        = 32;
   localparam int SRC_W         = 26;
   localparam int POS_W         = 7;
   localparam int CSR_IDX_W     = 3;

   localparam logic [DATA_W-1:0] COEF_H_RST  = 32'd7085;
   localparam logic [DATA_W-1:0] COEF_E_RST  = 32'd1005567000;
   localparam logic [POS_W-1:0]  SRC_POS_RST = 7'd33;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_STEP  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      FLD_EZ = 2'd0,
      FLD_HX = 2'd1,
      FLD_HY = 2'd2
   } fld_code_type;

   typedef enum logic [1:0] {
      OP_WRITE     = 2'd0,
      OP_READ      = 2'd1,
      OP_READ_MISS = 2'd2,
      OP_STEP      = 2'd3
   } op_type;

   typedef enum logic {
      RES_READ = 1'b0,
      RES_STEP = 1'b1
   } res_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_HX = 3'd0,
      CSR_COEF_HY = 3'd1,
      CSR_COEF_EX = 3'd2,
      CSR_COEF_EY = 3'd3,
      CSR_SRC_COL = 3'd4,
      CSR_SRC_ROW = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      PH_HX = 2'd0,
      PH_HY = 2'd1,
      PH_EZ = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      ST_CLR, ST_IDLE, ST_RDQ, ST_RESP, ST_RD0, ST_RD1, ST_DIF,
      ST_MLO, ST_MHI, ST_ACC, ST_WR, ST_SRC, ST_PECC, ST_PECR
   } state_type;

   typedef struct packed {
      op_type       op;
      fld_code_type fld;
   } cmd_type;

   // row-major flat index of a cell in a store of the given width
   function automatic int unsigned cell_addr(int unsigned c, int unsigned r,
                                             int unsigned w);
      return r * w + c;
   endfunction

endpackage

// ----- rtl/fdtd_2d_tm_grid_step_top.sv -----
// Top level of the 2D TM Yee grid step engine
//
// Requests (req_*) enter on a valid/stall channel: write cell, read cell or
// advance one time step. A read gives one response of kind 0 with the cell
// value, a step one response of kind 1 when the whole update is done; a
// write gives none. Responses (rsp_*) leave from an output register on a
// valid/stall channel; a stalled response holds and the engine waits for it.
// Coefficients and the source position are written on the csr_ port; the user
// must write them only while idle, which the block itself does not enforce.
// After reset the three stores are swept to zero, one address a cycle, over all
// (GRID_COLS+2)*(GRID_ROWS+2) Ez addresses; req_stall is high then.
// A two-entry queue decouples request decode from the sequencer.
// A step updates Hx, then Hy, then Ez; each product is formed from the low and
// high halves of the coefficient in turn, twice per Ez cell, and the source and
// PEC walls are written after the Ez sweep.
// One request is worked on at a time.
module fdtd_2d_tm_grid_step_top #(
   parameter int GRID_COLS = fdtd_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS = fdtd_pkg::GRID_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_req_type,
   input  logic [1:0]                          req_field_select,
   input  logic [fdtd_pkg::POS_W-1:0]          req_col,
   input  logic [fdtd_pkg::POS_W-1:0]          req_row,
   input  logic signed [fdtd_pkg::DATA_W-1:0]  req_value,
   input  logic signed [fdtd_pkg::SRC_W-1:0]   req_source_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_result_kind,
   output logic signed [fdtd_pkg::DATA_W-1:0]  rsp_read_value,
   input  logic                                csr_we,
   input  logic [fdtd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fdtd_pkg::DATA_W-1:0]         csr_wdata
);

   localparam int ENTRY_W = $bits(fdtd_pkg::cmd_type)
                            + $clog2((GRID_COLS + 2) * (GRID_ROWS + 2))
                            + fdtd_pkg::DATA_W;

   logic               clearing;
   logic               q_full, q_empty, q_push, q_pop;
   logic [ENTRY_W-1:0] q_in_data, q_out_data;

   fdtd_front #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_req_type     (req_req_type),
      .req_field_select (req_field_select),
      .req_col          (req_col),
      .req_row          (req_row),
      .req_value        (req_value),
      .req_source_value (req_source_value),
      .clearing         (clearing),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_in_data)
   );

   fdtd_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   fdtd_back #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_empty         (q_empty),
      .q_data          (q_out_data),
      .q_pop           (q_pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_read_value  (rsp_read_value)
   );

endmodule

// ----- rtl/fdtd_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module fdtd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4356
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/fdtd_front.sv -----
// Front end: accepts requests, range-checks and encodes them for the queue
module fdtd_front #(
   parameter int GRID_COLS = fdtd_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS = fdtd_pkg::GRID_ROWS_DEF
) (
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_req_type,
   input  logic [1:0]                          req_field_select,
   input  logic [fdtd_pkg::POS_W-1:0]          req_col,
   input  logic [fdtd_pkg::POS_W-1:0]          req_row,
   input  logic signed [fdtd_pkg::DATA_W-1:0]  req_value,
   input  logic signed [fdtd_pkg::SRC_W-1:0]   req_source_value,
   input  logic                                clearing,
   input  logic                                q_full,
   output logic                                q_push,
   output logic [$bits(fdtd_pkg::cmd_type)+$clog2((GRID_COLS+2)*(GRID_ROWS+2))
                 +fdtd_pkg::DATA_W-1:0]         q_data
);

   localparam int EZ_W  = GRID_COLS + 2;
   localparam int EZ_H  = GRID_ROWS + 2;
   localparam int HX_W  = GRID_COLS + 2;
   localparam int HX_H  = GRID_ROWS + 1;
   localparam int HY_W  = GRID_COLS + 1;
   localparam int HY_H  = GRID_ROWS + 2;
   localparam int EZ_AW = $clog2(EZ_W * EZ_H);

   fdtd_pkg::cmd_type        cmd;
   logic                     hit;
   logic                     keep;
   logic [EZ_AW-1:0]         addr;
   logic [fdtd_pkg::DATA_W-1:0] payload;
   int unsigned              c;
   int unsigned              r;

   assign c = 32'(req_col);
   assign r = 32'(req_row);

   always_comb begin
      hit     = 1'b0;
      addr    = '0;
      keep    = 1'b0;
      cmd.op  = fdtd_pkg::OP_WRITE;
      cmd.fld = fdtd_pkg::fld_code_type'(req_field_select);
      payload = req_value;
      unique case (fdtd_pkg::fld_code_type'(req_field_select))
         fdtd_pkg::FLD_EZ: begin
            hit  = (c < EZ_W) && (r < EZ_H);
            addr = EZ_AW'(fdtd_pkg::cell_addr(c, r, EZ_W));
         end
         fdtd_pkg::FLD_HX: begin
            hit  = (c < HX_W) && (r < HX_H);
            addr = EZ_AW'(fdtd_pkg::cell_addr(c, r, HX_W));
         end
         fdtd_pkg::FLD_HY: begin
            hit  = (c < HY_W) && (r < HY_H);
            addr = EZ_AW'(fdtd_pkg::cell_addr(c, r, HY_W));
         end
         default: hit = 1'b0;
      endcase
      unique case (fdtd_pkg::req_code_type'(req_req_type))
         fdtd_pkg::REQ_WRITE: begin
            cmd.op = fdtd_pkg::OP_WRITE;
            keep   = hit;
         end
         fdtd_pkg::REQ_READ: begin
            cmd.op = hit ? fdtd_pkg::OP_READ : fdtd_pkg::OP_READ_MISS;
            keep   = 1'b1;
         end
         fdtd_pkg::REQ_STEP: begin
            cmd.op  = fdtd_pkg::OP_STEP;
            keep    = 1'b1;
            payload = fdtd_pkg::DATA_W'(req_source_value);
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_stall = clearing | q_full;
   assign q_push    = req_valid & ~req_stall & keep;
   assign q_data    = {cmd, addr, payload};

endmodule

// ----- rtl/fdtd_queue.sv -----
// Two-entry request queue between front and back ends
module fdtd_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);

endmodule

// ----- rtl/fdtd_back.sv -----
// Back end: field stores, step sequencer, scaling unit and result register
`include "fdtd_2d_tm_grid_step_top_defines.svh"

module fdtd_back #(
   parameter int GRID_COLS = fdtd_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS = fdtd_pkg::GRID_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fdtd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fdtd_pkg::DATA_W-1:0]         csr_wdata,
   input  logic                                q_empty,
   input  logic [$bits(fdtd_pkg::cmd_type)+$clog2((GRID_COLS+2)*(GRID_ROWS+2))
                 +fdtd_pkg::DATA_W-1:0]         q_data,
   output logic                                q_pop,
   output logic                                clearing,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_result_kind,
   output logic signed [fdtd_pkg::DATA_W-1:0]  rsp_read_value
);

   localparam int EZ_W     = GRID_COLS + 2;
   localparam int EZ_H     = GRID_ROWS + 2;
   localparam int HX_W     = GRID_COLS + 2;
   localparam int HX_H     = GRID_ROWS + 1;
   localparam int HY_W     = GRID_COLS + 1;
   localparam int HY_H     = GRID_ROWS + 2;
   localparam int EZ_DEPTH = EZ_W * EZ_H;
   localparam int HX_DEPTH = HX_W * HX_H;
   localparam int HY_DEPTH = HY_W * HY_H;
   localparam int EZ_AW    = $clog2(EZ_DEPTH);
   localparam int HX_AW    = $clog2(HX_DEPTH);
   localparam int HY_AW    = $clog2(HY_DEPTH);
   localparam int IW       = $clog2(((GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS) + 3);
   localparam int CMD_W    = $bits(fdtd_pkg::cmd_type);
   localparam int DW       = fdtd_pkg::DATA_W;
   localparam logic signed [46:0] SAT_MAX = 47'sd2147483647;
   localparam logic signed [46:0] SAT_MIN = -47'sd2147483648;

   fdtd_pkg::cmd_type   q_cmd;
   logic [EZ_AW-1:0]    q_addr;
   logic [DW-1:0]       q_value;

   assign q_cmd   = fdtd_pkg::cmd_type'(q_data[CMD_W+EZ_AW+DW-1 -: CMD_W]);
   assign q_addr  = q_data[DW +: EZ_AW];
   assign q_value = q_data[DW-1:0];

   // configuration
   logic [DW-1:0]              coef_hx_ff, coef_hy_ff, coef_ex_ff, coef_ey_ff;
   logic [fdtd_pkg::POS_W-1:0] src_col_ff, src_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_hx_ff <= fdtd_pkg::COEF_H_RST;
         coef_hy_ff <= fdtd_pkg::COEF_H_RST;
         coef_ex_ff <= fdtd_pkg::COEF_E_RST;
         coef_ey_ff <= fdtd_pkg::COEF_E_RST;
         src_col_ff <= fdtd_pkg::SRC_POS_RST;
         src_row_ff <= fdtd_pkg::SRC_POS_RST;
      end else if (csr_we) begin
         case (fdtd_pkg::csr_idx_type'(csr_index))
            fdtd_pkg::CSR_COEF_HX: coef_hx_ff <= csr_wdata;
            fdtd_pkg::CSR_COEF_HY: coef_hy_ff <= csr_wdata;
            fdtd_pkg::CSR_COEF_EX: coef_ex_ff <= csr_wdata;
            fdtd_pkg::CSR_COEF_EY: coef_ey_ff <= csr_wdata;
            fdtd_pkg::CSR_SRC_COL: src_col_ff <= csr_wdata[fdtd_pkg::POS_W-1:0];
            fdtd_pkg::CSR_SRC_ROW: src_row_ff <= csr_wdata[fdtd_pkg::POS_W-1:0];
            default: ;
         endcase
      end
   end

   // stores
   logic             ez_we, hx_we, hy_we;
   logic [EZ_AW-1:0] ez_waddr, ez_raddr;
   logic [HX_AW-1:0] hx_waddr, hx_raddr;
   logic [HY_AW-1:0] hy_waddr, hy_raddr;
   logic [DW-1:0]    wr_data;
   logic [DW-1:0]    ez_rdata, hx_rdata, hy_rdata;

   fdtd_ram #(.WIDTH(DW), .DEPTH(EZ_DEPTH)) u_ez_ram (
      .clock(clock), .we(ez_we), .waddr(ez_waddr), .wdata(wr_data),
      .raddr(ez_raddr), .rdata(ez_rdata)
   );

   fdtd_ram #(.WIDTH(DW), .DEPTH(HX_DEPTH)) u_hx_ram (
      .clock(clock), .we(hx_we), .waddr(hx_waddr), .wdata(wr_data),
      .raddr(hx_raddr), .rdata(hx_rdata)
   );

   fdtd_ram #(.WIDTH(DW), .DEPTH(HY_DEPTH)) u_hy_ram (
      .clock(clock), .we(hy_we), .waddr(hy_waddr), .wdata(wr_data),
      .raddr(hy_raddr), .rdata(hy_rdata)
   );

   // sequencer state
   fdtd_pkg::state_type    state_ff, state_in;
   fdtd_pkg::phase_type    phase_ff, phase_in;
   logic                   pass_ff, pass_in;
   logic [IW-1:0]          i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                   side_ff, side_in;
   logic [EZ_AW-1:0]       clr_ff, clr_in;
   fdtd_pkg::fld_code_type rsel_ff, rsel_in;
   logic                   miss_ff, miss_in;
   logic                   res_kind_ff, res_kind_in;
   logic [DW-1:0]          res_value_ff, res_value_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [DW-1:0]          rsp_value_ff, rsp_value_in;
   logic                   rsp_load;

   // datapath
   logic signed [fdtd_pkg::SRC_W-1:0] src_ff, src_in;
   logic signed [DW-1:0]   base_ff, base_in, a1_ff, a1_in, a2_ff, a2_in;
   logic signed [DW:0]     d1_ff, d1_in, d2_ff, d2_in;
   logic signed [49:0]     plo_ff, plo_in, phi_ff, phi_in;
   logic signed [46:0]     acc_ff, acc_in;

   logic [DW-1:0]          coef_cur;
   logic signed [DW:0]     d_cur;
   logic                   sub_cur;
   logic signed [49:0]     mult_lo, mult_hi;
   logic signed [65:0]     prod_full;
   logic signed [43:0]     scaled;
   logic signed [46:0]     acc_sel;
   logic [DW-1:0]          sat_val;
   logic                   src_ok;
   int unsigned            ci, rj, imax, jmax;

   assign ci = 32'(i_ff);
   assign rj = 32'(j_ff);

   always_comb begin
      case (phase_ff)
         fdtd_pkg::PH_HX: coef_cur = coef_hx_ff;
         fdtd_pkg::PH_HY: coef_cur = coef_hy_ff;
         default:         coef_cur = pass_ff ? coef_ey_ff : coef_ex_ff;
      endcase
   end

   assign sub_cur   = (phase_ff == fdtd_pkg::PH_HX) ||
                      ((phase_ff == fdtd_pkg::PH_EZ) && pass_ff);
   assign d_cur     = pass_ff ? d2_ff : d1_ff;
   assign mult_lo   = $signed({1'b0, coef_cur[15:0]}) * d_cur;
   assign mult_hi   = $signed({1'b0, coef_cur[31:16]}) * d_cur;
   assign prod_full = (66'(phi_ff) <<< 16) + 66'(plo_ff);
   assign scaled    = 44'(prod_full >>> 22);
   assign acc_sel   = pass_ff ? acc_ff : 47'(base_ff);
   assign sat_val   = (acc_ff > SAT_MAX) ? 32'h7fff_ffff :
                      (acc_ff < SAT_MIN) ? 32'h8000_0000 : acc_ff[DW-1:0];
   assign src_ok    = (src_col_ff >= 7'd1) && (32'(src_col_ff) <= GRID_COLS) &&
                      (src_row_ff >= 7'd1) && (32'(src_row_ff) <= GRID_ROWS);
   assign imax      = (phase_ff == fdtd_pkg::PH_HY) ? GRID_COLS - 1 : GRID_COLS;
   assign jmax      = (phase_ff == fdtd_pkg::PH_HX) ? GRID_ROWS - 1 : GRID_ROWS;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdtd_pkg::ST_CLR;
         phase_ff     <= fdtd_pkg::PH_HX;
         pass_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pass_ff      <= pass_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      side_ff      <= side_in;
      rsel_ff      <= rsel_in;
      miss_ff      <= miss_in;
      res_kind_ff  <= res_kind_in;
      res_value_ff <= res_value_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      src_ff       <= src_in;
      base_ff      <= base_in;
      a1_ff        <= a1_in;
      a2_ff        <= a2_in;
      d1_ff        <= d1_in;
      d2_ff        <= d2_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      acc_ff       <= acc_in;
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pass_in      = pass_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      side_in      = side_ff;
      clr_in       = clr_ff;
      rsel_in      = rsel_ff;
      miss_in      = miss_ff;
      res_kind_in  = res_kind_ff;
      res_value_in = res_value_ff;
      src_in       = src_ff;
      base_in      = base_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      acc_in       = acc_ff;
      ez_we        = 1'b0;
      hx_we        = 1'b0;
      hy_we        = 1'b0;
      ez_waddr     = '0;
      hx_waddr     = '0;
      hy_waddr     = '0;
      wr_data      = '0;
      ez_raddr     = '0;
      hx_raddr     = '0;
      hy_raddr     = '0;
      q_pop        = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         fdtd_pkg::ST_CLR: begin
            ez_we    = 1'b1;
            hx_we    = (32'(clr_ff) < HX_DEPTH);
            hy_we    = (32'(clr_ff) < HY_DEPTH);
            ez_waddr = clr_ff;
            hx_waddr = clr_ff[HX_AW-1:0];
            hy_waddr = clr_ff[HY_AW-1:0];
            if (32'(clr_ff) == EZ_DEPTH - 1) begin
               state_in = fdtd_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         fdtd_pkg::ST_IDLE: begin
            ez_raddr = q_addr;
            hx_raddr = q_addr[HX_AW-1:0];
            hy_raddr = q_addr[HY_AW-1:0];
            if (!q_empty) begin
               q_pop = 1'b1;
               case (q_cmd.op)
                  fdtd_pkg::OP_WRITE: begin
                     wr_data  = q_value;
                     ez_waddr = q_addr;
                     hx_waddr = q_addr[HX_AW-1:0];
                     hy_waddr = q_addr[HY_AW-1:0];
                     ez_we    = (q_cmd.fld == fdtd_pkg::FLD_EZ);
                     hx_we    = (q_cmd.fld == fdtd_pkg::FLD_HX);
                     hy_we    = (q_cmd.fld == fdtd_pkg::FLD_HY);
                  end
                  fdtd_pkg::OP_READ: begin
                     rsel_in  = q_cmd.fld;
                     miss_in  = 1'b0;
                     state_in = fdtd_pkg::ST_RDQ;
                  end
                  fdtd_pkg::OP_READ_MISS: begin
                     miss_in  = 1'b1;
                     state_in = fdtd_pkg::ST_RDQ;
                  end
                  default: begin
                     src_in   = q_value[fdtd_pkg::SRC_W-1:0];
                     phase_in = fdtd_pkg::PH_HX;
                     pass_in  = 1'b0;
                     i_in     = IW'(1);
                     j_in     = IW'(1);
                     state_in = fdtd_pkg::ST_RD0;
                  end
               endcase
            end
         end
         fdtd_pkg::ST_RDQ: begin
            res_kind_in = fdtd_pkg::RES_READ;
            if (miss_ff) begin
               res_value_in = '0;
            end else begin
               case (rsel_ff)
                  fdtd_pkg::FLD_HX: res_value_in = hx_rdata;
                  fdtd_pkg::FLD_HY: res_value_in = hy_rdata;
                  default:          res_value_in = ez_rdata;
               endcase
            end
            state_in = fdtd_pkg::ST_RESP;
         end
         fdtd_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = fdtd_pkg::ST_IDLE;
            end
         end
         fdtd_pkg::ST_RD0: begin
            case (phase_ff)
               fdtd_pkg::PH_HX: ez_raddr = EZ_AW'(fdtd_pkg::cell_addr(ci, rj + 1, EZ_W));
               fdtd_pkg::PH_HY: ez_raddr = EZ_AW'(fdtd_pkg::cell_addr(ci + 1, rj, EZ_W));
               default:         ez_raddr = EZ_AW'(fdtd_pkg::cell_addr(ci, rj, EZ_W));
            endcase
            hx_raddr = HX_AW'(fdtd_pkg::cell_addr(ci, rj, HX_W));
            hy_raddr = HY_AW'(fdtd_pkg::cell_addr(ci, rj, HY_W));
            state_in = fdtd_pkg::ST_RD1;
         end
         fdtd_pkg::ST_RD1: begin
            case (phase_ff)
               fdtd_pkg::PH_HX: begin
                  base_in = $signed(hx_rdata);
                  a1_in   = $signed(ez_rdata);
               end
               fdtd_pkg::PH_HY: begin
                  base_in = $signed(hy_rdata);
                  a1_in   = $signed(ez_rdata);
               end
               default: begin
                  base_in = $signed(ez_rdata);
                  a1_in   = $signed(hy_rdata);
               end
            endcase
            a2_in    = $signed(hx_rdata);
            ez_raddr = EZ_AW'(fdtd_pkg::cell_addr(ci, rj, EZ_W));
            hy_raddr = HY_AW'(fdtd_pkg::cell_addr(ci - 1, rj, HY_W));
            hx_raddr = HX_AW'(fdtd_pkg::cell_addr(ci, rj - 1, HX_W));
            state_in = fdtd_pkg::ST_DIF;
         end
         fdtd_pkg::ST_DIF: begin
            if (phase_ff == fdtd_pkg::PH_EZ) begin
               d1_in = 33'(a1_ff) - 33'($signed(hy_rdata));
            end else begin
               d1_in = 33'(a1_ff) - 33'($signed(ez_rdata));
            end
            d2_in    = 33'(a2_ff) - 33'($signed(hx_rdata));
            state_in = fdtd_pkg::ST_MLO;
         end
         fdtd_pkg::ST_MLO: begin
            plo_in   = mult_lo;
            state_in = fdtd_pkg::ST_MHI;
         end
         fdtd_pkg::ST_MHI: begin
            phi_in   = mult_hi;
            state_in = fdtd_pkg::ST_ACC;
         end
         fdtd_pkg::ST_ACC: begin
            acc_in = sub_cur ? acc_sel - 47'(scaled) : acc_sel + 47'(scaled);
            if ((phase_ff == fdtd_pkg::PH_EZ) && !pass_ff) begin
               pass_in  = 1'b1;
               state_in = fdtd_pkg::ST_MLO;
            end else begin
               state_in = fdtd_pkg::ST_WR;
            end
         end
         fdtd_pkg::ST_WR: begin
            wr_data  = sat_val;
            ez_waddr = EZ_AW'(fdtd_pkg::cell_addr(ci, rj, EZ_W));
            hx_waddr = HX_AW'(fdtd_pkg::cell_addr(ci, rj, HX_W));
            hy_waddr = HY_AW'(fdtd_pkg::cell_addr(ci, rj, HY_W));
            ez_we    = (phase_ff == fdtd_pkg::PH_EZ);
            hx_we    = (phase_ff == fdtd_pkg::PH_HX);
            hy_we    = (phase_ff == fdtd_pkg::PH_HY);
            pass_in  = 1'b0;
            state_in = fdtd_pkg::ST_RD0;
            if (rj == jmax) begin
               j_in = IW'(1);
               if (ci == imax) begin
                  i_in = IW'(1);
                  case (phase_ff)
                     fdtd_pkg::PH_HX: phase_in = fdtd_pkg::PH_HY;
                     fdtd_pkg::PH_HY: phase_in = fdtd_pkg::PH_EZ;
                     default: begin
                        phase_in = fdtd_pkg::PH_HX;
                        state_in = fdtd_pkg::ST_SRC;
                     end
                  endcase
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         fdtd_pkg::ST_SRC: begin
            ez_we    = src_ok;
            ez_waddr = EZ_AW'(fdtd_pkg::cell_addr(32'(src_col_ff), 32'(src_row_ff), EZ_W));
            wr_data  = DW'(src_ff);
            k_in     = '0;
            side_in  = 1'b0;
            state_in = fdtd_pkg::ST_PECC;
         end
         fdtd_pkg::ST_PECC: begin
            ez_we    = 1'b1;
            ez_waddr = EZ_AW'(fdtd_pkg::cell_addr(side_ff ? GRID_COLS : 1, 32'(k_ff), EZ_W));
            side_in  = ~side_ff;
            if (side_ff) begin
               if (32'(k_ff) == EZ_H - 1) begin
                  k_in     = '0;
                  state_in = fdtd_pkg::ST_PECR;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         fdtd_pkg::ST_PECR: begin
            ez_we    = 1'b1;
            ez_waddr = EZ_AW'(fdtd_pkg::cell_addr(32'(k_ff), side_ff ? GRID_ROWS : 1, EZ_W));
            side_in  = ~side_ff;
            if (side_ff) begin
               if (32'(k_ff) == EZ_W - 1) begin
                  res_kind_in  = fdtd_pkg::RES_STEP;
                  res_value_in = '0;
                  state_in     = fdtd_pkg::ST_RESP;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: state_in = fdtd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = res_kind_ff;
         rsp_value_in = res_value_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign clearing        = (state_ff == fdtd_pkg::ST_CLR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_read_value  = rsp_value_ff;

   `FDTD_ASSERT_IMPL(a_pop_idle, q_pop, (state_ff == fdtd_pkg::ST_IDLE) && !q_empty, "pop outside idle")
   `FDTD_ASSERT_IMPL(a_rsp_slot, rsp_load, !rsp_valid_ff || !rsp_stall, "result overwritten")
   `FDTD_ASSERT_IMPL(a_pass_ez, pass_ff, phase_ff == fdtd_pkg::PH_EZ, "second scale outside Ez")
   `FDTD_ASSERT_NEXT(a_clr_quiet, state_ff == fdtd_pkg::ST_CLR, !rsp_valid_ff, "result during clear")

endmodule
